FILE: design/imfs_pkg.sv
package imfs_pkg;

    // field widths of the item channels
    localparam int SITE_W = 10;
    localparam int FRAC_W = 32;
    localparam int OUT_W  = 12;
    localparam int SIZE_W = 4;

    // size register after reset, before clamping
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd10;
    localparam int SIZE_MIN = 2;

    // long-bond partner of the first site, zero-based (site 3 one-based)
    localparam int FIRST_LONG_IDX = 2;

    // magnetization moves by two for every flipped spin
    localparam int SPIN_STEP = 2;

    typedef enum logic
    {
        ACT_RESTART = 1'b0,
        ACT_FLIP    = 1'b1
    } action_t;

    // classification handed from the front to the back
    typedef struct packed
    {
        logic restart;
        logic below_two;
        logic below_six;
    } job_ctrl_t;

endpackage

FILE: design/imfs_in_if.sv
interface imfs_in_if;

    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [imfs_pkg::SITE_W-1:0]   site_index;
    logic [imfs_pkg::FRAC_W-1:0]   random_fraction;
    logic [imfs_pkg::FRAC_W-1:0]   accept_limit_two;
    logic [imfs_pkg::FRAC_W-1:0]   accept_limit_six;

    modport source
    (
        output valid, action, site_index, random_fraction, accept_limit_two, accept_limit_six,
        input  ready
    );

    modport sink
    (
        input  valid, action, site_index, random_fraction, accept_limit_two, accept_limit_six,
        output ready
    );

endinterface

FILE: design/imfs_out_if.sv
interface imfs_out_if;

    logic                               valid;
    logic                               ready;
    logic                               accepted;
    logic                               sweep_end;
    logic signed [imfs_pkg::OUT_W-1:0]  energy;
    logic signed [imfs_pkg::OUT_W-1:0]  magnetization;
    logic signed [imfs_pkg::OUT_W-1:0]  min_energy;
    logic signed [imfs_pkg::OUT_W-1:0]  min_magnetization;

    modport source
    (
        output valid, accepted, sweep_end, energy, magnetization, min_energy,
               min_magnetization,
        input  ready
    );

    modport sink
    (
        input  valid, accepted, sweep_end, energy, magnetization, min_energy,
               min_magnetization,
        output ready
    );

endinterface

FILE: design/imfs_ram.sv
module imfs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first: a read at the write address returns the old word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: design/imfs_front.sv
module imfs_front #(
    parameter int MAX_LOG2 = 10,
    parameter int LG_W     = 4
) (
    input  logic [LG_W-1:0]      size_lg,
    imfs_in_if.sink              attempt,
    output logic                 push_valid,
    input  logic                 push_ready,
    output imfs_pkg::job_ctrl_t  job_ctrl,
    output logic [MAX_LOG2-1:0]  site_idx,
    output logic [MAX_LOG2-1:0]  prev_idx,
    output logic [MAX_LOG2-1:0]  next_idx,
    output logic [MAX_LOG2-1:0]  long_idx
);

    import imfs_pkg::*;

    logic [MAX_LOG2:0]   len_full;
    logic [MAX_LOG2:0]   half_full;
    logic [MAX_LOG2:0]   n_full;
    logic [MAX_LOG2:0]   low_bit;
    logic [MAX_LOG2:0]   step_full;
    logic [MAX_LOG2-1:0] len_mask;
    logic [MAX_LOG2-1:0] half_m1;
    logic [MAX_LOG2-1:0] step;
    logic                step_down;
    logic                is_first;
    logic                is_half;
    logic                is_last;

    assign len_full  = {{MAX_LOG2{1'b0}}, 1'b1} << size_lg;
    assign half_full = len_full >> 1;
    assign len_mask  = MAX_LOG2'(len_full - 1'b1);
    assign half_m1   = MAX_LOG2'(half_full - 1'b1);

    assign site_idx = MAX_LOG2'(attempt.site_index) & len_mask;
    assign n_full   = {1'b0, site_idx} + 1'b1;

    // lowest set bit of n, the long bond spans twice that
    assign low_bit   = n_full & (~n_full + 1'b1);
    assign step_full = low_bit << 1;
    assign step      = step_full[MAX_LOG2-1:0];
    assign step_down = |(n_full & step_full);

    assign is_first = (site_idx == '0);
    assign is_half  = (n_full == half_full);
    assign is_last  = (site_idx == len_mask);

    assign prev_idx = (site_idx - 1'b1) & len_mask;
    assign next_idx = (site_idx + 1'b1) & len_mask;

    // the ring neighbors hold everywhere, only the long bond has endpoint rules
    always_comb
    begin
        if (is_first)
        begin
            long_idx = MAX_LOG2'(FIRST_LONG_IDX);
        end
        else if (is_half)
        begin
            long_idx = len_mask;
        end
        else if (is_last)
        begin
            long_idx = half_m1;
        end
        else if (step_down)
        begin
            long_idx = (site_idx - step) & len_mask;
        end
        else
        begin
            long_idx = (site_idx + step) & len_mask;
        end
    end

    assign job_ctrl.restart   = (action_t'(attempt.action) == ACT_RESTART);
    assign job_ctrl.below_two = (attempt.random_fraction < attempt.accept_limit_two);
    assign job_ctrl.below_six = (attempt.random_fraction < attempt.accept_limit_six);

    assign push_valid    = attempt.valid;
    assign attempt.ready = push_ready;

endmodule

FILE: design/imfs_queue.sv
module imfs_queue #(
    parameter int WIDTH = 43,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

    a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not grow the queue");

endmodule

FILE: design/imfs_back.sv
module imfs_back #(
    parameter int MAX_LOG2 = 10,
    parameter int LG_W     = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [LG_W-1:0]      size_lg,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  imfs_pkg::job_ctrl_t  job_ctrl,
    input  logic [MAX_LOG2-1:0]  site_idx,
    input  logic [MAX_LOG2-1:0]  prev_idx,
    input  logic [MAX_LOG2-1:0]  next_idx,
    input  logic [MAX_LOG2-1:0]  long_idx,
    imfs_out_if.source           report
);

    import imfs_pkg::*;

    // spins are kept in rows, at most 256 rows so each row has a valid flop
    localparam int ROW_BITS = (MAX_LOG2 > 9) ? MAX_LOG2 - 8 : 1;
    localparam int ROW_W    = 1 << ROW_BITS;
    localparam int ROW_AW   = MAX_LOG2 - ROW_BITS;
    localparam int ROWS     = 1 << ROW_AW;
    localparam int TOT_W    = MAX_LOG2 + 2;
    localparam int RESET_LG = (MAX_LOG2 < int'(SIZE_RESET)) ? MAX_LOG2 : int'(SIZE_RESET);
    localparam logic signed [TOT_W-1:0] RESET_E = TOT_W'(3 * (1 << (RESET_LG - 1)));
    localparam logic signed [TOT_W-1:0] RESET_M = TOT_W'(1 << RESET_LG);

    typedef enum logic [1:0]
    {
        FWD_NONE,
        FWD_WRITE,
        FWD_RESTART
    } fwd_kind_t;

    // read issue
    logic              issue;
    logic              b2_advance;
    logic [ROW_AW-1:0] rd_row [3];
    logic [ROW_W-1:0]  rd_data [3];
    logic [2:0]        vld_q_reg;
    logic [ROWS-1:0]   valid_reg;

    // decide stage
    logic                b2_valid_reg;
    job_ctrl_t           b2_ctrl_reg;
    logic [MAX_LOG2-1:0] b2_site_reg;
    logic [MAX_LOG2-1:0] b2_prev_reg;
    logic [MAX_LOG2-1:0] b2_next_reg;
    logic [MAX_LOG2-1:0] b2_long_reg;
    logic [ROW_AW-1:0]   b2_row [3];
    logic [ROW_AW-1:0]   site_row;
    logic [ROW_BITS-1:0] site_off;
    logic [ROW_W-1:0]    eff [3];
    logic [ROW_W-1:0]    self_data;
    logic [ROW_W-1:0]    flip_data;
    logic                spin_self;
    logic                spin_prev;
    logic                spin_next;
    logic                spin_long;
    logic [1:0]          aligned;
    logic                take_flip;
    logic                take;
    logic signed [TOT_W-1:0] delta_e;
    logic signed [TOT_W-1:0] delta_m;

    // forwarding of the last decide-stage action
    fwd_kind_t         fwd_kind_reg;
    logic [ROW_AW-1:0] fwd_row_reg;
    logic [ROW_W-1:0]  fwd_data_reg;

    // totals
    logic signed [TOT_W-1:0] energy_reg;
    logic signed [TOT_W-1:0] energy_next;
    logic signed [TOT_W-1:0] magnet_reg;
    logic signed [TOT_W-1:0] magnet_next;
    logic signed [TOT_W-1:0] energy_floor_reg;
    logic signed [TOT_W-1:0] energy_floor_next;
    logic signed [TOT_W-1:0] magnet_floor_reg;
    logic signed [TOT_W-1:0] magnet_floor_next;
    logic [TOT_W-1:0]        len_tot;
    logic [MAX_LOG2-1:0]     sweep_pos_reg;
    logic [MAX_LOG2-1:0]     sweep_pos_next;
    logic [MAX_LOG2:0]       sweep_inc;
    logic [MAX_LOG2:0]       sweep_len;
    logic                    sweep_wrap;
    logic                    sweep_end_next;

    // output register
    logic                    out_valid_reg;
    logic                    out_accepted_reg;
    logic                    out_sweep_end_reg;
    logic signed [OUT_W-1:0] out_energy_reg;
    logic signed [OUT_W-1:0] out_magnet_reg;
    logic signed [OUT_W-1:0] out_energy_floor_reg;
    logic signed [OUT_W-1:0] out_magnet_floor_reg;

    assign b2_advance = b2_valid_reg && (!out_valid_reg || report.ready);
    assign pop_ready  = !b2_valid_reg || b2_advance;
    assign issue      = pop_valid && pop_ready;

    assign rd_row[0] = prev_idx[MAX_LOG2-1:ROW_BITS];
    assign rd_row[1] = next_idx[MAX_LOG2-1:ROW_BITS];
    assign rd_row[2] = long_idx[MAX_LOG2-1:ROW_BITS];

    assign b2_row[0] = b2_prev_reg[MAX_LOG2-1:ROW_BITS];
    assign b2_row[1] = b2_next_reg[MAX_LOG2-1:ROW_BITS];
    assign b2_row[2] = b2_long_reg[MAX_LOG2-1:ROW_BITS];
    assign site_row  = b2_site_reg[MAX_LOG2-1:ROW_BITS];
    assign site_off  = b2_site_reg[ROW_BITS-1:0];

    // three copies with identical writes give three read ports
    for (genvar k = 0; k < 3; k++)
    begin : g_copy
        imfs_ram #(
            .WIDTH (ROW_W),
            .DEPTH (ROWS)
        ) u_spin_ram (
            .clk     (clk),
            .wr_en   (b2_advance && take),
            .wr_addr (site_row),
            .wr_data (flip_data),
            .rd_en   (issue),
            .rd_addr (rd_row[k]),
            .rd_data (rd_data[k])
        );
    end

    // unwritten rows read as spin up; the previous item's write lands at our read edge
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (fwd_kind_reg == FWD_RESTART)
            begin
                eff[k] = '1;
            end
            else if (fwd_kind_reg == FWD_WRITE && fwd_row_reg == b2_row[k])
            begin
                eff[k] = fwd_data_reg;
            end
            else if (vld_q_reg[k])
            begin
                eff[k] = rd_data[k];
            end
            else
            begin
                eff[k] = '1;
            end
        end
    end

    // the site itself sits in the row of one of its ring neighbors
    assign self_data = (site_row == b2_row[0]) ? eff[0] : eff[1];
    assign flip_data = self_data ^ (ROW_W'(1) << site_off);
    assign spin_self = self_data[site_off];
    assign spin_prev = eff[0][b2_prev_reg[ROW_BITS-1:0]];
    assign spin_next = eff[1][b2_next_reg[ROW_BITS-1:0]];
    assign spin_long = eff[2][b2_long_reg[ROW_BITS-1:0]];

    assign aligned = {1'b0, spin_prev == spin_self} + {1'b0, spin_next == spin_self}
                   + {1'b0, spin_long == spin_self};

    // dE = 6 - 4 * aligned neighbors
    always_comb
    begin
        case (aligned)
            2'd0:
            begin
                take_flip = b2_ctrl_reg.below_six;
                delta_e   = TOT_W'(6);
            end
            2'd1:
            begin
                take_flip = b2_ctrl_reg.below_two;
                delta_e   = TOT_W'(2);
            end
            2'd2:
            begin
                take_flip = 1'b1;
                delta_e   = TOT_W'(-2);
            end
            default:
            begin
                take_flip = 1'b1;
                delta_e   = TOT_W'(-6);
            end
        endcase
    end

    assign take    = !b2_ctrl_reg.restart && take_flip;
    assign delta_m = spin_self ? TOT_W'(-SPIN_STEP) : TOT_W'(SPIN_STEP);
    assign len_tot = TOT_W'(1) << size_lg;

    assign sweep_inc  = {1'b0, sweep_pos_reg} + 1'b1;
    assign sweep_len  = {{MAX_LOG2{1'b0}}, 1'b1} << size_lg;
    assign sweep_wrap = (sweep_inc >= sweep_len);

    always_comb
    begin
        energy_next       = energy_reg;
        magnet_next       = magnet_reg;
        energy_floor_next = energy_floor_reg;
        magnet_floor_next = magnet_floor_reg;
        sweep_pos_next    = sweep_wrap ? '0 : sweep_inc[MAX_LOG2-1:0];
        sweep_end_next    = sweep_wrap;
        if (b2_ctrl_reg.restart)
        begin
            energy_next       = $signed(len_tot + (len_tot >> 1));
            magnet_next       = $signed(len_tot);
            energy_floor_next = energy_next;
            magnet_floor_next = magnet_next;
            sweep_pos_next    = '0;
            sweep_end_next    = 1'b0;
        end
        else if (take)
        begin
            energy_next = energy_reg + delta_e;
            magnet_next = magnet_reg + delta_m;
            if (energy_next < energy_floor_reg)
            begin
                energy_floor_next = energy_next;
            end
            if (magnet_next < magnet_floor_reg)
            begin
                magnet_floor_next = magnet_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b2_valid_reg     <= 1'b0;
            valid_reg        <= '0;
            fwd_kind_reg     <= FWD_NONE;
            energy_reg       <= RESET_E;
            magnet_reg       <= RESET_M;
            energy_floor_reg <= RESET_E;
            magnet_floor_reg <= RESET_M;
            sweep_pos_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                b2_valid_reg <= 1'b1;
            end
            else if (b2_advance)
            begin
                b2_valid_reg <= 1'b0;
            end

            if (b2_advance)
            begin
                energy_reg       <= energy_next;
                magnet_reg       <= magnet_next;
                energy_floor_reg <= energy_floor_next;
                magnet_floor_reg <= magnet_floor_next;
                sweep_pos_reg    <= sweep_pos_next;
                if (b2_ctrl_reg.restart)
                begin
                    valid_reg    <= '0;
                    fwd_kind_reg <= FWD_RESTART;
                end
                else if (take)
                begin
                    valid_reg[site_row] <= 1'b1;
                    fwd_kind_reg        <= FWD_WRITE;
                end
                else
                begin
                    fwd_kind_reg <= FWD_NONE;
                end
            end

            if (b2_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (report.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b2_ctrl_reg <= job_ctrl;
            b2_site_reg <= site_idx;
            b2_prev_reg <= prev_idx;
            b2_next_reg <= next_idx;
            b2_long_reg <= long_idx;
            for (int k = 0; k < 3; k++)
            begin
                vld_q_reg[k] <= valid_reg[rd_row[k]];
            end
        end
        if (b2_advance)
        begin
            fwd_row_reg          <= site_row;
            fwd_data_reg         <= flip_data;
            out_accepted_reg     <= take;
            out_sweep_end_reg    <= sweep_end_next;
            out_energy_reg       <= OUT_W'(energy_next);
            out_magnet_reg       <= OUT_W'(magnet_next);
            out_energy_floor_reg <= OUT_W'(energy_floor_next);
            out_magnet_floor_reg <= OUT_W'(magnet_floor_next);
        end
    end

    assign report.valid             = out_valid_reg;
    assign report.accepted          = out_accepted_reg;
    assign report.sweep_end         = out_sweep_end_reg;
    assign report.energy            = out_energy_reg;
    assign report.magnetization     = out_magnet_reg;
    assign report.min_energy        = out_energy_floor_reg;
    assign report.min_magnetization = out_magnet_floor_reg;

    a_energy_floor: assert property (@(posedge clk) disable iff (!rst_n)
        energy_floor_reg <= energy_reg)
        else $error("energy floor above energy");

    a_magnet_floor: assert property (@(posedge clk) disable iff (!rst_n)
        magnet_floor_reg <= magnet_reg)
        else $error("magnetization floor above magnetization");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (b2_advance && b2_ctrl_reg.restart) |=> (valid_reg == '0)
            && (fwd_kind_reg == FWD_RESTART))
        else $error("restart left spin rows marked written");

endmodule

FILE: design/ising_metropolis_flip_step.sv
// an accepted item passes the queue write, then the spin-row read, then the decide
// into the output register; throughput: one item per cycle unless report stalls,
// set by the spin-row read-modify-write of the decide stage, which forwards the row
// written by the item just before it
// reset: asynchronous active-low rst_n; all spins read as up through per-row valid
// flops, totals and minima load from 2^min(10, MAX_SITES_LOG2) sites, no clearing pass
module ising_metropolis_flip_step #(
    parameter int MAX_SITES_LOG2 = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [imfs_pkg::SIZE_W-1:0] cfg_write_data,
    imfs_in_if.sink                     attempt,
    imfs_out_if.source                  report
);

    import imfs_pkg::*;

    localparam int LG_W        = $clog2(MAX_SITES_LOG2 + 1);
    localparam int JOB_W       = $bits(job_ctrl_t) + 4 * MAX_SITES_LOG2;
    localparam int QUEUE_DEPTH = 4;

    // size register, clamped to the supported range where it is used
    logic [SIZE_W-1:0] size_cfg_reg;
    logic [LG_W-1:0]   size_lg;

    // front to queue
    logic                      push_valid;
    logic                      push_ready;
    job_ctrl_t                 push_ctrl;
    logic [MAX_SITES_LOG2-1:0] push_site;
    logic [MAX_SITES_LOG2-1:0] push_prev;
    logic [MAX_SITES_LOG2-1:0] push_next;
    logic [MAX_SITES_LOG2-1:0] push_long;
    logic [JOB_W-1:0]          push_data;

    // queue to back
    logic                      pop_valid;
    logic                      pop_ready;
    logic [JOB_W-1:0]          pop_data;
    job_ctrl_t                 pop_ctrl;
    logic [MAX_SITES_LOG2-1:0] pop_site;
    logic [MAX_SITES_LOG2-1:0] pop_prev;
    logic [MAX_SITES_LOG2-1:0] pop_next;
    logic [MAX_SITES_LOG2-1:0] pop_long;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_cfg_reg <= SIZE_RESET;
        end
        else if (cfg_write_en)
        begin
            size_cfg_reg <= cfg_write_data;
        end
    end

    // below the minimum acts as four sites, above the maximum as the full store
    always_comb
    begin
        if (int'(size_cfg_reg) < SIZE_MIN)
        begin
            size_lg = LG_W'(SIZE_MIN);
        end
        else if (int'(size_cfg_reg) > MAX_SITES_LOG2)
        begin
            size_lg = LG_W'(MAX_SITES_LOG2);
        end
        else
        begin
            size_lg = LG_W'(size_cfg_reg);
        end
    end

    // front: masks the site, finds the ring and long-bond neighbors and
    // compares the random fraction against both limits
    imfs_front #(
        .MAX_LOG2 (MAX_SITES_LOG2),
        .LG_W     (LG_W)
    ) u_front (
        .size_lg    (size_lg),
        .attempt    (attempt),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .job_ctrl   (push_ctrl),
        .site_idx   (push_site),
        .prev_idx   (push_prev),
        .next_idx   (push_next),
        .long_idx   (push_long)
    );

    assign push_data = {push_ctrl, push_site, push_prev, push_next, push_long};

    // short queue so the front keeps taking items while the back stalls
    imfs_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign {pop_ctrl, pop_site, pop_prev, pop_next, pop_long} = pop_data;

    // back: reads the spin rows, decides the flip, updates totals and minima,
    // counts the sweep and holds the result in its output register
    imfs_back #(
        .MAX_LOG2 (MAX_SITES_LOG2),
        .LG_W     (LG_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .size_lg   (size_lg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .job_ctrl  (pop_ctrl),
        .site_idx  (pop_site),
        .prev_idx  (pop_prev),
        .next_idx  (pop_next),
        .long_idx  (pop_long),
        .report    (report)
    );

endmodule
